@@ design/aarm_pkg.sv @@
// Shared constants, types and tables for the axis-angle rotation matrix block.
package aarm_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 14;
  localparam int ATAN_ENTRIES = 24;

  localparam int ANGLE_W = 17;
  localparam int AXIS_W  = 16;
  localparam int ENTRY_W = 16;

  // CORDIC datapath widths: x and y carry 30 fraction bits, z is 2^-23 degree.
  localparam int XY_W = 33;
  localparam int Z_W  = 34;

  localparam int FULL_TURN    = 46080;
  localparam int HALF_TURN    = 23040;
  localparam int QUARTER_TURN = 11520;

  localparam logic signed [XY_W-1:0] GAIN_INIT = XY_W'(652032874);
  localparam logic signed [XY_W-1:0] ONE_Q30   = XY_W'(1073741824);

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [AXIS_W-1:0]  axis_x;
    logic signed [AXIS_W-1:0]  axis_y;
    logic signed [AXIS_W-1:0]  axis_z;
  } axis_req_t;

  typedef struct packed {
    logic signed [ENTRY_W-1:0] row0_col0;
    logic signed [ENTRY_W-1:0] row0_col1;
    logic signed [ENTRY_W-1:0] row0_col2;
    logic signed [ENTRY_W-1:0] row1_col0;
    logic signed [ENTRY_W-1:0] row1_col1;
    logic signed [ENTRY_W-1:0] row1_col2;
    logic signed [ENTRY_W-1:0] row2_col0;
    logic signed [ENTRY_W-1:0] row2_col1;
    logic signed [ENTRY_W-1:0] row2_col2;
  } matrix_t;

  // State carried between the CORDIC stages.
  typedef struct packed {
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [Z_W-1:0]    z;
    logic                     flip;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
  } rot_state_t;

  function automatic logic signed [Z_W-1:0] atan_deg23(input logic [4:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:  v = Z_W'(377487360);
      5'd1:  v = Z_W'(222843801);
      5'd2:  v = Z_W'(117744544);
      5'd3:  v = Z_W'(59768969);
      5'd4:  v = Z_W'(30000467);
      5'd5:  v = Z_W'(15014858);
      5'd6:  v = Z_W'(7509261);
      5'd7:  v = Z_W'(3754860);
      5'd8:  v = Z_W'(1877459);
      5'd9:  v = Z_W'(938733);
      5'd10: v = Z_W'(469367);
      5'd11: v = Z_W'(234683);
      5'd12: v = Z_W'(117342);
      5'd13: v = Z_W'(58671);
      5'd14: v = Z_W'(29335);
      5'd15: v = Z_W'(14668);
      5'd16: v = Z_W'(7334);
      5'd17: v = Z_W'(3667);
      5'd18: v = Z_W'(1833);
      5'd19: v = Z_W'(917);
      5'd20: v = Z_W'(458);
      5'd21: v = Z_W'(229);
      5'd22: v = Z_W'(115);
      5'd23: v = Z_W'(57);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ design/aarm_if.sv @@
// Valid/ready channel interface carrying one payload.
interface aarm_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/aarm_fold.sv @@
// Angle negation and folding into [-90, 90] degrees, one register stage.
module aarm_fold (
  input  logic                     clk,
  input  logic                     en,
  input  aarm_pkg::axis_req_t      req,
  output aarm_pkg::rot_state_t     st
);
  logic signed [18:0] neg;
  logic signed [18:0] r;
  logic signed [18:0] r2;
  logic               flip;

  always_comb begin
    neg = -19'(req.angle);
    r = neg;
    // Inputs up to one turn past either side: at most two corrections each way.
    if (r < -19'(aarm_pkg::HALF_TURN)) r = r + 19'(aarm_pkg::FULL_TURN);
    if (r < -19'(aarm_pkg::HALF_TURN)) r = r + 19'(aarm_pkg::FULL_TURN);
    if (r > 19'(aarm_pkg::HALF_TURN)) r = r - 19'(aarm_pkg::FULL_TURN);
    if (r > 19'(aarm_pkg::HALF_TURN)) r = r - 19'(aarm_pkg::FULL_TURN);
    // Minus one half turn maps to plus one half turn.
    if (r == -19'(aarm_pkg::HALF_TURN)) r = 19'(aarm_pkg::HALF_TURN);
    r2 = r;
    flip = 1'b0;
    if (r > 19'(aarm_pkg::QUARTER_TURN)) begin
      r2 = r - 19'(aarm_pkg::HALF_TURN);
      flip = 1'b1;
    end else if (r < -19'(aarm_pkg::QUARTER_TURN)) begin
      r2 = r + 19'(aarm_pkg::HALF_TURN);
      flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st.x      <= aarm_pkg::GAIN_INIT;
      st.y      <= '0;
      // The folded angle fits in 18 signed bits; scale it by 2^16 into z.
      st.z      <= {r2[aarm_pkg::Z_W-17:0], 16'd0};
      st.flip   <= flip;
      st.axis_x <= req.axis_x;
      st.axis_y <= req.axis_y;
      st.axis_z <= req.axis_z;
    end
  end
endmodule

@@ design/aarm_cordic_stage.sv @@
// One registered CORDIC micro-rotation.
module aarm_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  aarm_pkg::rot_state_t st_in,
  output aarm_pkg::rot_state_t st_out
);
  aarm_pkg::rot_state_t st_next;
  logic signed [aarm_pkg::XY_W-1:0] dx;
  logic signed [aarm_pkg::XY_W-1:0] dy;
  logic signed [aarm_pkg::Z_W-1:0]  at;

  always_comb begin
    dx = st_in.y >>> STEP;
    dy = st_in.x >>> STEP;
    at = aarm_pkg::atan_deg23(5'(STEP));
    st_next = st_in;
    if (!st_in.z[aarm_pkg::Z_W-1]) begin
      st_next.x = st_in.x - dx;
      st_next.y = st_in.y + dy;
      st_next.z = st_in.z - at;
    end else begin
      st_next.x = st_in.x + dx;
      st_next.y = st_in.y - dy;
      st_next.z = st_in.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) st_out <= st_next;
  end
endmodule

@@ design/aarm_entry.sv @@
// Matrix entry arithmetic: products, sums, rounding and saturation in three stages.
module aarm_entry (
  input  logic                 clk,
  input  logic                 en,
  input  aarm_pkg::rot_state_t st,
  output aarm_pkg::matrix_t    mat
);
  localparam int F = aarm_pkg::FRAC_BITS;
  localparam int ACC_W = 64;

  // Stage A: c, s, t and the six pairwise axis products.
  logic signed [aarm_pkg::XY_W-1:0] c_a, s_a, t_a;
  logic signed [2*aarm_pkg::AXIS_W-1:0] p_a [6];
  logic signed [aarm_pkg::AXIS_W-1:0] ax_a, ay_a, az_a;
  // Stage B: p*t terms, r*s terms and scaled c.
  logic signed [ACC_W-1:0] pt_b [6];
  logic signed [ACC_W-1:0] rs_b [3];
  logic signed [ACC_W-1:0] c_b;
  logic signed [ACC_W-1:0] sum [9];
  logic signed [ACC_W-1:0] rnd [9];
  logic signed [aarm_pkg::ENTRY_W-1:0] sat [9];
  logic signed [aarm_pkg::XY_W-1:0] c_w, s_w;

  always_comb begin
    c_w = st.flip ? -st.x : st.x;
    s_w = st.flip ? -st.y : st.y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_a  <= c_w;
      s_a  <= s_w;
      t_a  <= aarm_pkg::ONE_Q30 - c_w;
      p_a[0] <= st.axis_x * st.axis_x;
      p_a[1] <= st.axis_x * st.axis_y;
      p_a[2] <= st.axis_x * st.axis_z;
      p_a[3] <= st.axis_y * st.axis_y;
      p_a[4] <= st.axis_y * st.axis_z;
      p_a[5] <= st.axis_z * st.axis_z;
      ax_a <= st.axis_x;
      ay_a <= st.axis_y;
      az_a <= st.axis_z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        pt_b[k] <= (ACC_W'(p_a[k]) * ACC_W'(t_a)) >>> F;
      end
      rs_b[0] <= ACC_W'(ax_a) * ACC_W'(s_a);
      rs_b[1] <= ACC_W'(ay_a) * ACC_W'(s_a);
      rs_b[2] <= ACC_W'(az_a) * ACC_W'(s_a);
      c_b     <= ACC_W'(c_a) <<< F;
    end
  end

  always_comb begin
    sum[0] = pt_b[0] + c_b;
    sum[1] = pt_b[1] - rs_b[2];
    sum[2] = pt_b[2] + rs_b[1];
    sum[3] = pt_b[1] + rs_b[2];
    sum[4] = pt_b[3] + c_b;
    sum[5] = pt_b[4] - rs_b[0];
    sum[6] = pt_b[2] - rs_b[1];
    sum[7] = pt_b[4] + rs_b[0];
    sum[8] = pt_b[5] + c_b;
    for (int k = 0; k < 9; k++) begin
      rnd[k] = (sum[k] + (ACC_W'(1) <<< 29)) >>> 30;
      if (rnd[k] > ACC_W'(32767)) sat[k] = 16'sh7fff;
      else if (rnd[k] < -ACC_W'(32768)) sat[k] = 16'sh8000;
      else sat[k] = rnd[k][aarm_pkg::ENTRY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mat.row0_col0 <= sat[0];
      mat.row0_col1 <= sat[1];
      mat.row0_col2 <= sat[2];
      mat.row1_col0 <= sat[3];
      mat.row1_col1 <= sat[4];
      mat.row1_col2 <= sat[5];
      mat.row2_col0 <= sat[6];
      mat.row2_col1 <= sat[7];
      mat.row2_col2 <= sat[8];
    end
  end
endmodule

@@ design/axis_angle_rotation_matrix.sv @@
// Axis-angle rotation matrix built as one registered pipeline.
// Throughput one request per cycle; the whole pipeline advances when the output
// register is empty or being taken, so a stall freezes every stage together.
// Depth is set by one register per CORDIC micro-rotation plus fold and three
// arithmetic stages. Synchronous active-high reset clears the valid bits only.
module axis_angle_rotation_matrix #(
  parameter int CORDIC_STEPS = aarm_pkg::CORDIC_STEPS
) (
  input  logic  clk,
  input  logic  rst,
  aarm_if.sink   req,
  aarm_if.source rsp
);
  localparam int DEPTH = 1 + CORDIC_STEPS + 3;

  // One valid bit per pipeline stage; the last one is the output register.
  logic [DEPTH-1:0] vld;
  logic             adv;

  aarm_pkg::rot_state_t st [CORDIC_STEPS+1];

  // The pipeline moves whenever the final stage is free or being drained.
  assign adv       = !vld[DEPTH-1] || rsp.ready;
  assign req.ready = adv;
  assign rsp.valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], req.valid};
    end
  end

  aarm_fold u_fold (
    .clk (clk),
    .en  (adv),
    .req (req.data),
    .st  (st[0])
  );

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    aarm_cordic_stage #(.STEP(g)) u_stage (
      .clk    (clk),
      .en     (adv),
      .st_in  (st[g]),
      .st_out (st[g+1])
    );
  end

  aarm_entry u_entry (
    .clk (clk),
    .en  (adv),
    .st  (st[CORDIC_STEPS]),
    .mat (rsp.data)
  );

  // A request taken while the output stalls would be lost.
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !req.ready)
    else $error("request accepted during output stall");

  // A request accepted shows up as a valid bit in the first stage.
  a_first_stage: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> vld[0])
    else $error("accepted request lost at entry");

  // A stalled pipeline keeps its valid pattern.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!adv) |=> $stable(vld))
    else $error("valid bits moved during stall");
endmodule
